FILE: sv/rar_pkg.sv
`default_nettype none
package rar_pkg;
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned MAG_W = 64;

	localparam logic [2:0] ACT_NORM = 3'd0;
	localparam logic [2:0] ACT_ADD  = 3'd1;
	localparam logic [2:0] ACT_SUB  = 3'd2;
	localparam logic [2:0] ACT_MUL  = 3'd3;
	localparam logic [2:0] ACT_DIV  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// datapath commands
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_COMBINE,
		OP_GCD,
		OP_DIV
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_den;
		logic zero_num;
		logic gcd_done;
		logic div_done;
	} dp_stat_t;
endpackage
`default_nettype wire

FILE: sv/rational_arith_reduce.sv
`default_nettype none
// Rational arithmetic unit: takes an action and two fractions, returns the
// reduced result with sign on the numerator. One item at a time: after a word
// is accepted, the unit forms the cross products, combines them, checks for
// zero, seeds the Euclid GCD and runs its remainder steps (each a restoring
// division, one bit per cycle), sees the GCD done, then divides numerator and
// denominator by it and loads the result into the output register; the next
// word can be taken once that load is done. The number of remainder steps
// depends on the operands: full-range operands need many more than small ones.
// Zero numerators and zero denominators skip the GCD and divides and go
// straight to the output register. The output register lets the next word
// start while a result waits for the receiver.
module rational_arith_reduce #(
	parameter int unsigned VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
	input  wire logic [135:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// res_num[31:0], res_den[62:32], status[64:63]
	output logic [71:0]      m_tdata
);
	rar_pkg::dp_cmd_t  cmd;
	rar_pkg::dp_stat_t stat;
	logic busy, done;
	logic [1:0] st;
	logic [31:0] rn;
	logic [30:0] rd;
	logic        out_load;
	logic        out_valid_q;
	logic [71:0] out_data_q;

	assign s_tready = !busy;
	assign out_load = done && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_data_q <= {7'd0, st, rd, rn};
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	rar_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(out_load),
		.stat(stat), .cmd(cmd), .busy(busy), .done(done)
	);

	rar_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .cmd(cmd), .action(s_tdata[2:0]),
		.a_num(s_tdata[34:3]), .a_den(s_tdata[66:35]),
		.b_num(s_tdata[98:67]), .b_den(s_tdata[130:99]),
		.stat(stat), .res_status(st), .res_num(rn), .res_den(rd)
	);
endmodule
`default_nettype wire

FILE: sv/rar_datapath.sv
`default_nettype none
module rar_datapath #(
	parameter int unsigned VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire rar_pkg::dp_cmd_t     cmd,
	input  wire logic [2:0]           action,
	input  wire logic [31:0]          a_num,
	input  wire logic [31:0]          a_den,
	input  wire logic [31:0]          b_num,
	input  wire logic [31:0]          b_den,
	output rar_pkg::dp_stat_t         stat,
	output logic [1:0]                res_status,
	output logic [31:0]               res_num,
	output logic [30:0]               res_den
);
	localparam int unsigned W = VALUE_WIDTH;
	localparam int unsigned M = rar_pkg::MAG_W;
	localparam logic [M-1:0] LIMIT = M'(1) << (W - 1);

	logic [2:0]   act_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;   // magnitudes
	logic         ans_q, ads_q, bns_q, bds_q;
	logic [M-1:0] p0_q, p1_q, den_q;
	logic         p0s_q, p1s_q, dens_q;
	logic [M-1:0] num_q;
	logic         nums_q;
	logic [M-1:0] gx_q, gy_q;
	logic [M-1:0] rem_q, quo_q;
	logic [M-1:0] nm_q, dm_q;
	logic [5:0]   bit_q;
	logic         divsel_q;
	logic         zden_q;

	function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
		logic [W-1:0] v;
		v = raw[W-1:0];
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	// cross products of the operand magnitudes
	logic [W-1:0]   mul_b0, mul_b2;
	logic [2*W-1:0] prod0, prod1, prod2;
	assign mul_b0 = (act_q == rar_pkg::ACT_MUL) ? bn_q : bd_q;
	assign mul_b2 = (act_q == rar_pkg::ACT_DIV) ? bn_q : bd_q;
	assign prod0 = an_q * mul_b0;
	assign prod1 = bn_q * ad_q;
	assign prod2 = ad_q * mul_b2;

	// one restoring step of the final divides by the gcd
	logic [M:0]   trial;
	logic [M-1:0] rem_sh;
	logic [M-1:0] dividend;
	assign dividend = divsel_q ? den_q : num_q;
	assign rem_sh = {rem_q[M-2:0], dividend[bit_q]};
	assign trial = {1'b0, rem_sh} - {1'b0, gx_q};

	// gcd uses its own dividend gx_q
	logic [M-1:0] grem_sh;
	logic [M:0]   gtrial;
	assign grem_sh = {rem_q[M-2:0], gx_q[bit_q]};
	assign gtrial = {1'b0, grem_sh} - {1'b0, gy_q};

	logic neg;
	assign neg = nums_q != dens_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rar_pkg::OP_LOAD: begin
				act_q <= action;
				an_q <= mag_of(a_num); ans_q <= a_num[W-1];
				ad_q <= mag_of(a_den); ads_q <= a_den[W-1];
				bn_q <= mag_of(b_num);
				bns_q <= b_num[W-1] ^ (action == rar_pkg::ACT_SUB);
				bd_q <= mag_of(b_den); bds_q <= b_den[W-1];
				zden_q <= (mag_of(a_den) == '0);
			end
			rar_pkg::OP_MUL: begin
				unique case (act_q)
					rar_pkg::ACT_ADD, rar_pkg::ACT_SUB: begin
						p0_q <= M'(prod0); p0s_q <= ans_q ^ bds_q;
						p1_q <= M'(prod1); p1s_q <= bns_q ^ ads_q;
						den_q <= M'(prod2); dens_q <= ads_q ^ bds_q;
					end
					rar_pkg::ACT_MUL: begin
						p0_q <= M'(prod0); p0s_q <= ans_q ^ bns_q;
						p1_q <= '0; p1s_q <= 1'b0;
						den_q <= M'(prod2); dens_q <= ads_q ^ bds_q;
					end
					rar_pkg::ACT_DIV: begin
						p0_q <= M'(prod0); p0s_q <= ans_q ^ bds_q;
						p1_q <= '0; p1s_q <= 1'b0;
						den_q <= M'(prod2); dens_q <= ads_q ^ bns_q;
					end
					default: begin
						p0_q <= M'(an_q); p0s_q <= ans_q;
						p1_q <= '0; p1s_q <= 1'b0;
						den_q <= M'(ad_q); dens_q <= ads_q;
					end
				endcase
				if (ad_q == '0) zden_q <= 1'b1;
			end
			rar_pkg::OP_COMBINE: begin
				// signed-magnitude add
				if (p0s_q == p1s_q) begin
					num_q <= p0_q + p1_q; nums_q <= p0s_q;
				end else if (p0_q >= p1_q) begin
					num_q <= p0_q - p1_q; nums_q <= p0s_q;
				end else begin
					num_q <= p1_q - p0_q; nums_q <= p1s_q;
				end
				if (den_q == '0) zden_q <= 1'b1;
				gx_q <= '0; gy_q <= '0; rem_q <= '0; bit_q <= 6'(M - 1);
			end
			rar_pkg::OP_GCD: begin
				if (gy_q == '0 && gx_q == '0) begin
					// first entry: seed x, y
					gx_q <= (num_q == '0) ? '0 : num_q;
					gy_q <= den_q;
					rem_q <= '0; bit_q <= 6'(M - 1);
				end else if (bit_q == '0) begin
					gx_q <= gy_q;
					gy_q <= gtrial[M] ? grem_sh : gtrial[M-1:0];
					rem_q <= '0; bit_q <= 6'(M - 1);
				end else begin
					rem_q <= gtrial[M] ? grem_sh : gtrial[M-1:0];
					bit_q <= bit_q - 6'd1;
				end
				divsel_q <= 1'b0; quo_q <= '0;
			end
			rar_pkg::OP_DIV: begin
				if (bit_q == '0) begin
					bit_q <= 6'(M - 1); rem_q <= '0; quo_q <= '0;
					divsel_q <= 1'b1;
					if (divsel_q) dm_q <= {quo_q[M-2:0], ~trial[M]};
					else nm_q <= {quo_q[M-2:0], ~trial[M]};
				end else begin
					quo_q <= {quo_q[M-2:0], ~trial[M]};
					rem_q <= trial[M] ? rem_sh : trial[M-1:0];
					bit_q <= bit_q - 6'd1;
				end
			end
			default: ;
		endcase
	end

	assign stat.zero_den = zden_q;
	assign stat.zero_num = (num_q == '0);
	assign stat.gcd_done = (gy_q == '0) && (gx_q != '0);
	assign stat.div_done = divsel_q && (bit_q == '0);

	// result formatting from the final quotients
	logic ovf;
	logic [M-1:0] nneg;
	assign ovf = (dm_q >= LIMIT) || (neg ? (nm_q > LIMIT) : (nm_q >= LIMIT));
	assign nneg = neg ? (M'(0) - nm_q) : nm_q;
	always_comb begin
		if (zden_q) begin
			res_status = rar_pkg::ST_ZDEN; res_num = '0; res_den = '0;
		end else if (num_q == '0) begin
			res_status = rar_pkg::ST_OK; res_num = '0; res_den = 31'd1;
		end else if (ovf) begin
			res_status = rar_pkg::ST_OVF; res_num = '0; res_den = '0;
		end else begin
			res_status = rar_pkg::ST_OK; res_num = nneg[31:0]; res_den = dm_q[30:0];
		end
	end
endmodule
`default_nettype wire

FILE: sv/rar_ctrl.sv
`default_nettype none
module rar_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              out_fire,
	input  wire rar_pkg::dp_stat_t stat,
	output rar_pkg::dp_cmd_t       cmd,
	output logic                   busy,
	output logic                   done
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_CHK, S_GCD, S_DIV, S_OUT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_MUL;
				S_MUL: state_q <= S_COMB;
				S_COMB: state_q <= S_CHK;
				S_CHK: state_q <= (stat.zero_den || stat.zero_num) ? S_OUT : S_GCD;
				S_GCD: if (stat.gcd_done) state_q <= S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		unique case (state_q)
			S_IDLE: cmd.op = in_fire ? rar_pkg::OP_LOAD : rar_pkg::OP_NONE;
			S_MUL: cmd.op = rar_pkg::OP_MUL;
			S_COMB: cmd.op = rar_pkg::OP_COMBINE;
			S_GCD: cmd.op = stat.gcd_done ? rar_pkg::OP_NONE : rar_pkg::OP_GCD;
			S_DIV: cmd.op = rar_pkg::OP_DIV;
			default: cmd.op = rar_pkg::OP_NONE;
		endcase
	end
	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_fire) |=> done) else $error("result dropped");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> cmd.op != rar_pkg::OP_LOAD) else $error("load while busy");
	a_fire_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy) else $error("item lost");
endmodule
`default_nettype wire
